// ----- hdl/rsi_pkg.sv -----
package rsi_pkg;

  localparam int unsigned DIR_W      = 18;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DIST_W     = 34;
  localparam int unsigned DISC_SHIFT = 32;
  localparam int unsigned DIST_TOP   = FRAC_W + DIST_W;

endpackage

// ----- hdl/rsi_in_if.sv -----
interface rsi_in_if
  import rsi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [DIR_W-1:0]       dir_x;
  logic signed [DIR_W-1:0]       dir_y;
  logic signed [DIR_W-1:0]       dir_z;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [COORD_WIDTH-2:0] radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    output ready
  );
endinterface

// ----- hdl/rsi_out_if.sv -----
interface rsi_out_if
  import rsi_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

// ----- hdl/ray_sphere_intersection_top.sv -----
// Ray-sphere intersection test, fully pipelined: while the output is not stalled, one
// ray/sphere pair is taken per cycle and one result (hit, Q34.0 distance) leaves per cycle.
// The square root resolves one result bit per pipeline stage; its result width SQ_W is
// half the even-rounded discriminant width (54 for COORD_WIDTH = 32). Results leave in
// input order. When the output is stalled the whole pipeline holds.
module ray_sphere_intersection_top
  import rsi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rsi_in_if.sink       in_i,
  rsi_out_if.source    out_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned MW    = CW + 1;
  localparam int unsigned PW    = MW + DIR_W;
  localparam int unsigned BW    = PW + 2;
  localparam int unsigned MMW   = 2 * MW;
  localparam int unsigned RRW   = 2 * CW - 2;
  localparam int unsigned CTW   = MMW + 3;
  localparam int unsigned LO_W  = (BW + 1) / 2;
  localparam int unsigned HI_W  = BW - LO_W;
  localparam int unsigned BBW   = 2 * BW;
  localparam int unsigned CSW   = CTW + DISC_SHIFT;
  localparam int unsigned DW    = ((BBW > CSW) ? BBW : CSW) + 1;
  localparam int unsigned QW    = DW + (DW % 2);
  localparam int unsigned SQ_W  = QW / 2;
  localparam int unsigned REMW  = SQ_W + 2;
  localparam int unsigned RTW0  = ((BW > SQ_W) ? BW : SQ_W) + 2;
  localparam int unsigned RTW   = (RTW0 > DIST_TOP + 1) ? RTW0 : DIST_TOP + 1;

  typedef struct packed {
    logic [BW-1:0] b;
    logic          neg_b;
    logic          neg_c;
    logic          pos_c;
    logic          miss;
  } side_t;

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // stage 1: m = origin - center
  logic              v1_q;
  logic signed [MW-1:0]    m_q [3];
  logic signed [DIR_W-1:0] d_q [3];
  logic        [CW-2:0]    rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0] <= MW'(in_i.origin_x) - MW'(in_i.center_x);
      m_q[1] <= MW'(in_i.origin_y) - MW'(in_i.center_y);
      m_q[2] <= MW'(in_i.origin_z) - MW'(in_i.center_z);
      d_q[0] <= in_i.dir_x;
      d_q[1] <= in_i.dir_y;
      d_q[2] <= in_i.dir_z;
      rad_q  <= in_i.radius;
    end
  end

  // stage 2: products
  logic                  v2_q;
  logic signed [PW-1:0]  pd_q [3];
  logic signed [MMW-1:0] mm_q [3];
  logic        [RRW-1:0] rr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd_q[i] <= PW'(m_q[i]) * PW'(d_q[i]);
        mm_q[i] <= MMW'(m_q[i]) * MMW'(m_q[i]);
      end
      rr_q <= RRW'(rad_q) * RRW'(rad_q);
    end
  end

  // stage 3: b and c
  logic                  v3_q;
  logic signed [BW-1:0]  b_q;
  logic signed [CTW-1:0] c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q <= BW'(pd_q[0]) + BW'(pd_q[1]) + BW'(pd_q[2]);
      c_q <= CTW'(mm_q[0]) + CTW'(mm_q[1]) + CTW'(mm_q[2])
           - $signed({{(CTW-RRW){1'b0}}, rr_q});
    end
  end

  // stage 4: partial products of b*b
  logic                       v4_q;
  logic        [BW-1:0]       ab;
  logic        [2*HI_W-1:0]   hh_q;
  logic        [BW-1:0]       hl_q;
  logic        [2*LO_W-1:0]   ll_q;
  logic signed [CTW-1:0]      c4_q;
  side_t                      side4_q;

  assign ab = b_q[BW-1] ? BW'(-b_q) : BW'(b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh_q          <= (2*HI_W)'(ab[BW-1:LO_W]) * (2*HI_W)'(ab[BW-1:LO_W]);
      hl_q          <= BW'(ab[BW-1:LO_W]) * BW'(ab[LO_W-1:0]);
      ll_q          <= (2*LO_W)'(ab[LO_W-1:0]) * (2*LO_W)'(ab[LO_W-1:0]);
      c4_q          <= c_q;
      side4_q.b     <= b_q;
      side4_q.neg_b <= b_q[BW-1];
      side4_q.neg_c <= c_q[CTW-1];
      side4_q.pos_c <= !c_q[CTW-1] && (c_q != '0);
      side4_q.miss  <= 1'b0;
    end
  end

  // discriminant, then square root one bit per stage
  logic [BBW-1:0]       bb;
  logic signed [DW-1:0] disc;
  side_t                sd0;

  assign bb   = (BBW'(hh_q) << (2 * LO_W)) + (BBW'(hl_q) << (LO_W + 1)) + BBW'(ll_q);
  assign disc = $signed({{(DW-BBW){1'b0}}, bb}) - (DW'(c4_q) <<< DISC_SHIFT);

  always_comb begin
    sd0      = side4_q;
    sd0.miss = disc[DW-1];
  end

  logic [SQ_W:0]   sv_q;
  logic [REMW-1:0] rem_q [SQ_W+1];
  logic [SQ_W-1:0] rt_q  [SQ_W+1];
  logic [QW-1:0]   qd_q  [SQ_W+1];
  side_t           sd_q  [SQ_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[SQ_W-1:0], v4_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]      <= '0;
      rt_q[0]       <= '0;
      qd_q[0]       <= disc[DW-1] ? '0 : {{(QW-DW+1){1'b0}}, disc[DW-2:0]};
      sd_q[0]       <= sd0;
    end
  end

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            ge;

    assign rem_sh = {rem_q[k][REMW-3:0], qd_q[k][QW-1:QW-2]};
    assign trial  = {rt_q[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1] <= ge ? rem_sh - trial : rem_sh;
        rt_q[k+1]  <= {rt_q[k][SQ_W-2:0], ge};
        qd_q[k+1]  <= {qd_q[k][QW-3:0], 2'b00};
        sd_q[k+1]  <= sd_q[k];
      end
    end
  end

  // root selection and output register
  side_t                sf;
  logic signed [RTW-1:0] nb;
  logic signed [RTW-1:0] sq;
  logic signed [RTW-1:0] root;
  logic                  near;
  logic                  hit;
  logic                  hit_q;
  logic [DIST_W-1:0]     dist_q;

  assign sf   = sd_q[SQ_W];
  assign nb   = -RTW'($signed(sf.b));
  assign sq   = $signed({{(RTW-SQ_W){1'b0}}, rt_q[SQ_W]});
  assign near = sf.neg_b && sf.pos_c;
  assign root = near ? nb - sq : nb + sq;
  assign hit  = !sf.miss && (sf.neg_b || sf.neg_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sv_q[SQ_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit;
      if (!hit) begin
        dist_q <= '0;
      end else if (root[RTW-1:DIST_TOP] != '0) begin
        dist_q <= '1;
      end else begin
        dist_q <= root[DIST_TOP-1:FRAC_W];
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.hit      = hit_q;
  assign out_o.distance = dist_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.hit |-> out_o.distance == '0)
    else $error("miss with nonzero distance");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v1_q)
    else $error("transfer lost at pipeline entry");

  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[SQ_W] |-> rem_q[SQ_W] <= {1'b0, rt_q[SQ_W], 1'b0})
    else $error("square root remainder out of range");

endmodule
